FILE: src/musa_pkg.sv
// shared types and constants for the minimum unsorted subarray unit
package musa_pkg;

	localparam int IN_VALUE_W = 32;
	localparam int OUT_INDEX_W = 10;

	typedef enum logic [1:0] {
		MODE_MINMAX,
		MODE_LEFT,
		MODE_RIGHT
	} scan_mode_t;

	typedef struct packed {
		logic       load;
		logic       scan_start;
		scan_mode_t mode;
		logic       report;
	} dp_cmd_t;

	typedef struct packed {
		logic trivial;
		logic scan_idle;
	} dp_stat_t;

endpackage

FILE: src/minimum_unsorted_subarray_unit.sv
// top level of the minimum unsorted subarray unit
//
// channel   direction  handshake               fields
// element   in         start high, busy low    value, last
// result    out        done strobe, one cycle  is_sorted, left_index, right_index, too_long
//
// elements transfer one per cycle while busy is low; the item with last set ends the array
// sorted or single-element arrays: the controller goes from load through the check and report
// states to the result strobe; otherwise the strobe follows three passes of the single
// read port of the element store (span min/max, left search, right search), which together
// read each stored element once; an empty left or right search issues no reads
// reset clears all control state; the store needs no clearing
// the receiver cannot stall: done is high for a single cycle, fields hold until the next report
module minimum_unsorted_subarray_unit #(
	parameter int MAX_LEN = 1024,
	parameter int VALUE_BITS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [musa_pkg::IN_VALUE_W-1:0]  value,
	input  logic                             last,
	output logic                             done,
	output logic                             is_sorted,
	output logic [musa_pkg::OUT_INDEX_W-1:0] left_index,
	output logic [musa_pkg::OUT_INDEX_W-1:0] right_index,
	output logic                             too_long
);

	import musa_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	musa_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.last  (last),
		.stat  (stat),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	musa_dp #(
		.MAX_LEN   (MAX_LEN),
		.VALUE_BITS(VALUE_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.value      (value),
		.stat       (stat),
		.is_sorted  (is_sorted),
		.left_index (left_index),
		.right_index(right_index),
		.too_long   (too_long)
	);

endmodule

FILE: src/musa_ram.sv
// generic simple dual-port ram with registered read
module musa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: src/musa_ctrl.sv
// controller state machine sequencing load, scans and result
module musa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               last,
	input  musa_pkg::dp_stat_t stat,
	output musa_pkg::dp_cmd_t  cmd,
	output logic               busy,
	output logic               done
);

	import musa_pkg::*;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_CHECK,
		ST_MM_GO,
		ST_MM_WAIT,
		ST_LEFT_GO,
		ST_LEFT_WAIT,
		ST_RIGHT_GO,
		ST_RIGHT_WAIT,
		ST_REPORT
	} state_t;

	state_t state_q;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == ST_REPORT);
			unique case (state_q)
				ST_LOAD: begin
					if (start && last) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					state_q <= stat.trivial ? ST_REPORT : ST_MM_GO;
				end
				ST_MM_GO: begin
					state_q <= ST_MM_WAIT;
				end
				ST_MM_WAIT: begin
					if (stat.scan_idle) begin
						state_q <= ST_LEFT_GO;
					end
				end
				ST_LEFT_GO: begin
					state_q <= ST_LEFT_WAIT;
				end
				ST_LEFT_WAIT: begin
					if (stat.scan_idle) begin
						state_q <= ST_RIGHT_GO;
					end
				end
				ST_RIGHT_GO: begin
					state_q <= ST_RIGHT_WAIT;
				end
				ST_RIGHT_WAIT: begin
					if (stat.scan_idle) begin
						state_q <= ST_REPORT;
					end
				end
				ST_REPORT: begin
					state_q <= ST_LOAD;
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		cmd.load = start && (state_q == ST_LOAD);
		unique case (state_q)
			ST_MM_GO: begin
				cmd.scan_start = 1'b1;
				cmd.mode = MODE_MINMAX;
			end
			ST_LEFT_GO: begin
				cmd.scan_start = 1'b1;
				cmd.mode = MODE_LEFT;
			end
			ST_RIGHT_GO: begin
				cmd.scan_start = 1'b1;
				cmd.mode = MODE_RIGHT;
			end
			ST_REPORT: begin
				cmd.report = 1'b1;
			end
			default: begin
				cmd.mode = MODE_MINMAX;
			end
		endcase
	end

	assign busy = (state_q != ST_LOAD);
	assign done = done_q;

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held for more than one cycle");

	a_report_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REPORT) |-> $past(stat.trivial) || $past(stat.scan_idle))
		else $error("result reported while a scan was still running");

endmodule

FILE: src/musa_dp.sv
// datapath: element store, descent tracking, scan engine and result registers
module musa_dp #(
	parameter int MAX_LEN = 1024,
	parameter int VALUE_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  musa_pkg::dp_cmd_t                   cmd,
	input  logic [musa_pkg::IN_VALUE_W-1:0]     value,
	output musa_pkg::dp_stat_t                  stat,
	output logic                                is_sorted,
	output logic [musa_pkg::OUT_INDEX_W-1:0]    left_index,
	output logic [musa_pkg::OUT_INDEX_W-1:0]    right_index,
	output logic                                too_long
);

	import musa_pkg::*;

	localparam int IW = $clog2(MAX_LEN);
	localparam int CW = $clog2(MAX_LEN + 1);
	localparam int VW = VALUE_BITS;

	logic [CW-1:0] count_q;
	logic [VW-1:0] prev_q;
	logic [IW-1:0] first_q;
	logic [IW-1:0] last_q;
	logic          desc_q;
	logic          ovf_q;

	scan_mode_t    mode_q;
	logic          issuing_q;
	logic          down_q;
	logic [IW-1:0] addr_q;
	logic [IW-1:0] end_q;
	logic          rd_v_s1;
	logic [IW-1:0] rd_idx_s1;

	logic [VW-1:0] mn_q;
	logic [VW-1:0] mx_q;
	logic [IW-1:0] lo_q;
	logic [IW-1:0] hi_q;
	logic          found_q;

	logic                   res_sorted_q;
	logic [OUT_INDEX_W-1:0] res_left_q;
	logic [OUT_INDEX_W-1:0] res_right_q;
	logic                   res_long_q;

	logic [VW+IN_VALUE_W-1:0]   value_ext;
	logic [VW-1:0]              v;
	logic                       full;
	logic                       store_we;
	logic [IW-1:0]              wr_idx;
	logic [IW-1:0]              count_m1;
	logic [VW-1:0]              rd_data;
	logic                       trivial;
	logic [IW+OUT_INDEX_W-1:0]  lo_ext;
	logic [IW+OUT_INDEX_W-1:0]  hi_ext;

	assign value_ext = {{VW{1'b0}}, value};
	assign v         = value_ext[VW-1:0];
	assign full      = (count_q == CW'(MAX_LEN));
	assign store_we  = cmd.load && !full;
	assign wr_idx    = count_q[IW-1:0];
	assign count_m1  = IW'(count_q - 1'b1);
	assign trivial   = (count_q <= CW'(1)) || !desc_q;
	assign lo_ext    = {{OUT_INDEX_W{1'b0}}, lo_q};
	assign hi_ext    = {{OUT_INDEX_W{1'b0}}, hi_q};

	musa_ram #(
		.WIDTH(VW),
		.DEPTH(MAX_LEN)
	) u_store (
		.clk  (clk),
		.we   (store_we),
		.waddr(wr_idx),
		.wdata(v),
		.raddr(addr_q),
		.rdata(rd_data)
	);

	// array loading and descent tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			prev_q  <= '0;
			first_q <= '0;
			last_q  <= '0;
			desc_q  <= 1'b0;
			ovf_q   <= 1'b0;
		end else if (cmd.report) begin
			count_q <= '0;
			prev_q  <= '0;
			first_q <= '0;
			last_q  <= '0;
			desc_q  <= 1'b0;
			ovf_q   <= 1'b0;
		end else if (cmd.load) begin
			if (full) begin
				ovf_q <= 1'b1;
			end else begin
				if ((count_q != '0) && (prev_q > v)) begin
					if (!desc_q) begin
						first_q <= wr_idx - 1'b1;
					end
					last_q <= wr_idx;
					desc_q <= 1'b1;
				end
				prev_q  <= v;
				count_q <= count_q + 1'b1;
			end
		end
	end

	// address sequencer over the store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_MINMAX;
			issuing_q <= 1'b0;
			down_q    <= 1'b0;
			addr_q    <= '0;
			end_q     <= '0;
			rd_v_s1   <= 1'b0;
			rd_idx_s1 <= '0;
		end else begin
			rd_v_s1   <= issuing_q;
			rd_idx_s1 <= addr_q;
			if (cmd.scan_start) begin
				mode_q <= cmd.mode;
				case (cmd.mode)
					MODE_LEFT: begin
						addr_q    <= '0;
						end_q     <= first_q - 1'b1;
						down_q    <= 1'b0;
						issuing_q <= (first_q != '0);
					end
					MODE_RIGHT: begin
						addr_q    <= count_m1;
						end_q     <= last_q + 1'b1;
						down_q    <= 1'b1;
						issuing_q <= (last_q != count_m1);
					end
					default: begin
						addr_q    <= first_q;
						end_q     <= last_q;
						down_q    <= 1'b0;
						issuing_q <= 1'b1;
					end
				endcase
			end else if (issuing_q) begin
				if (addr_q == end_q) begin
					issuing_q <= 1'b0;
				end else if (down_q) begin
					addr_q <= addr_q - 1'b1;
				end else begin
					addr_q <= addr_q + 1'b1;
				end
			end
		end
	end

	// scan evaluation on returning read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.scan_start) begin
			found_q <= 1'b0;
		end else if (rd_v_s1 && !found_q) begin
			case (mode_q)
				MODE_LEFT:  found_q <= (rd_data > mn_q);
				MODE_RIGHT: found_q <= (rd_data < mx_q);
				default:    found_q <= 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			case (cmd.mode)
				MODE_LEFT:  lo_q <= first_q;
				MODE_RIGHT: hi_q <= last_q;
				default: begin
					mn_q <= '1;
					mx_q <= '0;
				end
			endcase
		end else if (rd_v_s1) begin
			case (mode_q)
				MODE_LEFT: begin
					if (!found_q && (rd_data > mn_q)) begin
						lo_q <= rd_idx_s1;
					end
				end
				MODE_RIGHT: begin
					if (!found_q && (rd_data < mx_q)) begin
						hi_q <= rd_idx_s1;
					end
				end
				default: begin
					if (rd_data < mn_q) begin
						mn_q <= rd_data;
					end
					if (rd_data > mx_q) begin
						mx_q <= rd_data;
					end
				end
			endcase
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.report) begin
			res_sorted_q <= trivial;
			res_left_q   <= trivial ? '0 : lo_ext[OUT_INDEX_W-1:0];
			res_right_q  <= trivial ? '0 : hi_ext[OUT_INDEX_W-1:0];
			res_long_q   <= ovf_q;
		end
	end

	assign stat.trivial   = trivial;
	assign stat.scan_idle = !issuing_q && !rd_v_s1;

	assign is_sorted   = res_sorted_q;
	assign left_index  = res_left_q;
	assign right_index = res_right_q;
	assign too_long    = res_long_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_LEN))
		else $error("element count beyond capacity");

	a_bounds_order: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.report && !trivial) |-> (lo_q <= first_q) && (first_q <= last_q)
			&& (last_q <= hi_q))
		else $error("subarray bounds out of order");

	a_scan_no_load: assert property (@(posedge clk) disable iff (!arst_n)
		(issuing_q || rd_v_s1) |-> !cmd.load)
		else $error("element transfer taken during a scan");

	a_read_follows_issue: assert property (@(posedge clk) disable iff (!arst_n)
		rd_v_s1 |-> $past(issuing_q))
		else $error("read data marked valid without an issued address");

endmodule
